// File: rtl/btst_pkg.sv
`timescale 1ns / 1ps
// btst_pkg: shared types and constants for the bounded time-sorted table
// holds the command and result words, table entry layout and sequencer states
// no dependencies
package btst_pkg;

  // field widths fixed by the command and result words
  localparam int unsigned ID_W     = 16;
  localparam int unsigned GATE_W   = 8;
  localparam int unsigned MINUTE_W = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd7;
  localparam logic [STATUS_W-1:0] STATUS_CLEAR   = 3'd0;
  localparam logic [CAP_W-1:0]    CAP_RESET      = 5'd10;

  // actions carried in the command word
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SET    = 2'd2,
    ACT_LOOKUP = 2'd3
  } btst_action_t;

  // result codes
  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_NOT_FOUND  = 2'd1,
    RES_DUPLICATE  = 2'd2,
    RES_BAD_STATUS = 2'd3
  } btst_code_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SCAN  = 3'd1,
    ST_PLAN  = 3'd2,
    ST_SHIFT = 3'd3,
    ST_DONE  = 3'd4
  } btst_state_t;

  // command word
  typedef struct packed {
    logic [1:0]          action;
    logic [ID_W-1:0]     entry_id;
    logic [GATE_W-1:0]   gate_number;
    logic [MINUTE_W-1:0] minute_of_day;
    logic [STATUS_W-1:0] status_code;
  } btst_in_t;

  // result word
  typedef struct packed {
    logic [1:0]          result_code;
    logic [ID_W-1:0]     out_id;
    logic [GATE_W-1:0]   out_gate;
    logic [MINUTE_W-1:0] out_minute;
    logic [STATUS_W-1:0] out_status;
    logic                evicted_flag;
    logic [ID_W-1:0]     evicted_id;
    logic [MINUTE_W-1:0] evicted_minute;
    logic [COUNT_W-1:0]  entry_count;
  } btst_out_t;

  // one stored table entry
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [GATE_W-1:0]   gate;
    logic [MINUTE_W-1:0] minute;
    logic [STATUS_W-1:0] status;
  } btst_entry_t;

  // compare unit flags
  typedef struct packed {
    logic id_hit;
    logic not_before;
  } btst_cmp_t;

endpackage

// File: rtl/btst_mem.sv
`timescale 1ns / 1ps
// btst_mem: table storage, one write port and one registered read port
// depends on btst_pkg for the entry layout
module btst_mem
  import btst_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output btst_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  btst_entry_t       wr_data
);

  btst_entry_t mem_r [DEPTH];

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

  // write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

endmodule

// File: rtl/btst_cmp.sv
`timescale 1ns / 1ps
// btst_cmp: shared compare unit, checks one entry read from the table
// against the id and time of the command; depends on btst_pkg
module btst_cmp
  import btst_pkg::*;
(
  input  btst_entry_t         entry,
  input  logic [ID_W-1:0]     key_id,
  input  logic [MINUTE_W-1:0] key_minute,
  output btst_cmp_t           flags
);

  // id match and time order of the stored entry against the new one
  always_comb begin
    flags.id_hit     = (entry.id == key_id);
    flags.not_before = (entry.minute >= key_minute);
  end

endmodule

// File: rtl/btst_ctrl.sv
`timescale 1ns / 1ps
// btst_ctrl: sequencer for the time-sorted table, a search pass then a shift pass
// depends on btst_pkg, btst_mem and btst_cmp
module btst_ctrl
  import btst_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  btst_in_t         in_word,
  input  logic [CAP_W-1:0] cap_limit,
  output logic             busy,
  output logic             res_vld,
  output btst_out_t        res_word
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  btst_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  btst_in_t    cmd_r;
  logic [CW-1:0] idx_r;
  logic        chk_vld_r;
  logic [CW-1:0] chk_idx_r;
  logic        hit_r;
  logic [CW-1:0] pos_r;
  btst_entry_t hit_ent_r;
  logic        at_found_r;
  logic [CW-1:0] at_r;
  logic [ID_W-1:0]     head_id_r;
  logic [MINUTE_W-1:0] head_min_r;

  logic        up_r;
  logic [CW-1:0] src_r;
  logic [CW-1:0] mv_r;
  logic        sh_vld_r;
  logic [CW-1:0] sh_dst_r;
  logic        fin_we_r;
  logic [CW-1:0] fin_idx_r;
  btst_entry_t fin_ent_r;
  btst_out_t   res_r;

  logic        rd_en;
  logic [CW-1:0] rd_idx;
  btst_entry_t rd_data;
  logic        wr_en;
  logic [CW-1:0] wr_idx;
  btst_entry_t wr_data;
  btst_cmp_t   cmp_flags;

  logic        scan_end;
  logic        shift_end;

  // plan of the action, worked out after the search pass
  btst_entry_t   new_ent;
  btst_entry_t   upd_ent;
  logic [LW-1:0] lim_eff;
  logic          evict;
  btst_out_t     p_res;
  logic [CW-1:0] p_cnt;
  logic          p_up;
  logic [CW-1:0] p_src;
  logic [CW-1:0] p_mv;
  logic          p_fin_we;
  logic [CW-1:0] p_fin_idx;
  btst_entry_t   p_fin_ent;

  btst_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data)
  );

  btst_cmp u_cmp (
    .entry      (rd_data),
    .key_id     (cmd_r.entry_id),
    .key_minute (cmd_r.minute_of_day),
    .flags      (cmp_flags)
  );

  assign scan_end  = (idx_r == cnt_r) && !chk_vld_r;
  assign shift_end = (mv_r == '0) && !sh_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_PLAN;
      ST_PLAN:  state_nxt = ST_SHIFT;
      ST_SHIFT: if (shift_end) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    busy    = (state_r != ST_IDLE);
    res_vld = (state_r == ST_DONE);
    rd_en   = 1'b0;
    rd_idx  = idx_r;
    wr_en   = 1'b0;
    wr_idx  = sh_dst_r;
    wr_data = rd_data;
    case (state_r)
      ST_SCAN: begin
        rd_en  = (idx_r < cnt_r);
        rd_idx = idx_r;
      end
      ST_SHIFT: begin
        rd_en  = (mv_r != '0);
        rd_idx = src_r;
        if (sh_vld_r) begin
          wr_en   = 1'b1;
          wr_idx  = sh_dst_r;
          wr_data = rd_data;
        end else if (shift_end && fin_we_r) begin
          wr_en   = 1'b1;
          wr_idx  = fin_idx_r;
          wr_data = fin_ent_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign res_word = res_r;

  // effective limit and eviction check
  always_comb begin
    lim_eff = (LW'(cap_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_limit);
    evict   = (LW'(cnt_r) >= lim_eff);
  end

  // new entry and status update
  always_comb begin
    new_ent.id     = cmd_r.entry_id;
    new_ent.gate   = cmd_r.gate_number;
    new_ent.minute = cmd_r.minute_of_day;
    new_ent.status = (cmd_r.status_code == STATUS_INVALID) ? STATUS_CLEAR
                                                           : cmd_r.status_code;
    upd_ent        = hit_ent_r;
    upd_ent.status = cmd_r.status_code;
  end

  // action plan: result word, new count, shift range and final write
  always_comb begin
    p_res     = '0;
    p_cnt     = cnt_r;
    p_up      = 1'b0;
    p_src     = '0;
    p_mv      = '0;
    p_fin_we  = 1'b0;
    p_fin_idx = '0;
    p_fin_ent = new_ent;
    if (cmd_r.action == ACT_INSERT) begin
      if (hit_r) begin
        p_res.result_code = RES_DUPLICATE;
        p_res.out_id      = hit_ent_r.id;
        p_res.out_gate    = hit_ent_r.gate;
        p_res.out_minute  = hit_ent_r.minute;
        p_res.out_status  = hit_ent_r.status;
      end else begin
        p_res.result_code = RES_OK;
        p_res.out_id      = new_ent.id;
        p_res.out_gate    = new_ent.gate;
        p_res.out_minute  = new_ent.minute;
        p_res.out_status  = new_ent.status;
        if (!evict) begin
          // open a slot: move the later entries up by one
          p_up      = 1'b1;
          p_src     = CW'(cnt_r - CW'(1));
          p_mv      = CW'(cnt_r - at_r);
          p_fin_we  = 1'b1;
          p_fin_idx = at_r;
          p_cnt     = CW'(cnt_r + CW'(1));
        end else if (at_r == '0) begin
          // new entry is the earliest and leaves at once
          p_res.evicted_flag   = 1'b1;
          p_res.evicted_id     = new_ent.id;
          p_res.evicted_minute = new_ent.minute;
        end else begin
          // head leaves: move the earlier entries down by one
          p_res.evicted_flag   = 1'b1;
          p_res.evicted_id     = head_id_r;
          p_res.evicted_minute = head_min_r;
          p_src     = CW'(1);
          p_mv      = CW'(at_r - CW'(1));
          p_fin_we  = 1'b1;
          p_fin_idx = CW'(at_r - CW'(1));
        end
      end
    end else if (!hit_r) begin
      p_res.result_code = RES_NOT_FOUND;
    end else begin
      p_res.result_code = RES_OK;
      p_res.out_id      = hit_ent_r.id;
      p_res.out_gate    = hit_ent_r.gate;
      p_res.out_minute  = hit_ent_r.minute;
      p_res.out_status  = hit_ent_r.status;
      case (cmd_r.action)
        ACT_DELETE: begin
          // close the gap: move the later entries down by one
          p_src = CW'(pos_r + CW'(1));
          p_mv  = CW'(cnt_r - pos_r - CW'(1));
          p_cnt = CW'(cnt_r - CW'(1));
        end
        ACT_SET: begin
          if (cmd_r.status_code == STATUS_INVALID) begin
            p_res.result_code = RES_BAD_STATUS;
          end else begin
            p_res.out_status = upd_ent.status;
            p_fin_we         = 1'b1;
            p_fin_idx        = pos_r;
            p_fin_ent        = upd_ent;
          end
        end
        default: begin
          p_res.result_code = RES_OK;
        end
      endcase
    end
    p_res.entry_count = COUNT_W'(p_cnt);
  end

  assign cnt_nxt = (state_r == ST_PLAN) ? p_cnt : cnt_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      sh_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= (state_r == ST_SCAN) && rd_en;
      sh_vld_r  <= (state_r == ST_SHIFT) && rd_en;
    end
  end

  // search pass and shift pass datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_r      <= in_word;
          idx_r      <= '0;
          hit_r      <= 1'b0;
          at_found_r <= 1'b0;
          at_r       <= cnt_r;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_r <= CW'(idx_r + CW'(1));
        end
        chk_idx_r <= idx_r;
        if (chk_vld_r) begin
          if (chk_idx_r == '0) begin
            head_id_r  <= rd_data.id;
            head_min_r <= rd_data.minute;
          end
          if (cmp_flags.id_hit && !hit_r) begin
            hit_r     <= 1'b1;
            pos_r     <= chk_idx_r;
            hit_ent_r <= rd_data;
          end
          if (cmp_flags.not_before && !at_found_r) begin
            at_found_r <= 1'b1;
            at_r       <= chk_idx_r;
          end
        end
      end
      ST_PLAN: begin
        res_r     <= p_res;
        up_r      <= p_up;
        src_r     <= p_src;
        mv_r      <= p_mv;
        fin_we_r  <= p_fin_we;
        fin_idx_r <= p_fin_idx;
        fin_ent_r <= p_fin_ent;
      end
      ST_SHIFT: begin
        if (rd_en) begin
          src_r    <= up_r ? CW'(src_r - CW'(1)) : CW'(src_r + CW'(1));
          mv_r     <= CW'(mv_r - CW'(1));
          sh_dst_r <= up_r ? CW'(src_r + CW'(1)) : CW'(src_r - CW'(1));
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_idx < CW'(DEPTH)))
    else $error("table write beyond depth");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r == ST_IDLE))
    else $error("result strobe longer than one cycle");

  a_no_evict_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && (res_r.result_code != RES_OK)) |-> !res_r.evicted_flag)
    else $error("eviction reported on a failed action");

endmodule

// File: rtl/bounded_time_sorted_table.sv
`timescale 1ns / 1ps
// bounded_time_sorted_table: top level, limit register and command sequencer
// depends on btst_pkg and btst_ctrl
//
// A command word is taken when start is high and busy is low; busy then stays
// high until the result word has been shown. The result is on out_word for
// exactly one cycle with out_strobe high and cannot be held off. One pass reads
// the table, one entry a cycle, to find the id and the insert point. A planning
// state then works out the action. A second pass moves entries one a cycle
// through the single table read port, then writes the last moved entry and the
// final entry. A done state shows the result. The next command can be taken in
// the cycle after the strobe. The table has no clearing pass after reset. The
// limit register may be written at any time through cfg_valid/cfg_ready but
// should only change while idle.
module bounded_time_sorted_table
  import btst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  btst_in_t         in_word,
  output logic             out_strobe,
  output btst_out_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0] cap_r, cap_nxt;

  // limit register
  assign cfg_ready = 1'b1;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // command sequencer with table storage
  btst_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .cap_limit (cap_r),
    .busy      (busy),
    .res_vld   (out_strobe),
    .res_word  (out_word)
  );

endmodule

// File: tb/tb_bounded_time_sorted_table.sv
`timescale 1ns / 1ps
// tb_bounded_time_sorted_table: self-checking bench for the bounded time-sorted table
// depends on btst_pkg and bounded_time_sorted_table; a tracker class predicts each result word
module tb_bounded_time_sorted_table;
  import btst_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int RAND_WORDS = 1800;
  localparam int POOL_SIZE = 24;
  localparam int PRINT_CAP = 100;

  // tracks table contents and the limit, and holds the result words still owed
  class sorted_table_tracker;
    btst_entry_t tbl[TBL_DEPTH];
    int held;
    int cap;
    btst_out_t owed_words[$];
    int mismatch_count;

    function new();
      held = 0;
      cap = int'(CAP_RESET);
      mismatch_count = 0;
    endfunction

    function void set_limit(logic [CAP_W-1:0] v);
      cap = int'(v);
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function logic [ID_W-1:0] pick_held_id();
      if (held == 0) begin
        return ID_W'($urandom);
      end
      return tbl[$urandom_range(held - 1, 0)].id;
    endfunction

    function btst_out_t with_entry(btst_out_t r, btst_entry_t e);
      r.out_id = e.id;
      r.out_gate = e.gate;
      r.out_minute = e.minute;
      r.out_status = e.status;
      return r;
    endfunction

    // next state of the table and the result word one command produces
    function btst_out_t apply_command(btst_in_t c);
      btst_out_t r;
      btst_entry_t fresh;
      btst_entry_t grown[TBL_DEPTH+1];
      int pos;
      int at;
      int n;
      int lim;
      r = '0;
      pos = -1;
      for (int i = 0; i < held; i++) begin
        if (pos < 0 && tbl[i].id == c.entry_id) pos = i;
      end
      if (btst_action_t'(c.action) == ACT_INSERT) begin
        if (pos >= 0) begin
          r.result_code = RES_DUPLICATE;
          r = with_entry(r, tbl[pos]);
        end else begin
          fresh.id = c.entry_id;
          fresh.gate = c.gate_number;
          fresh.minute = c.minute_of_day;
          fresh.status = (c.status_code == STATUS_INVALID) ? STATUS_CLEAR : c.status_code;
          // new entry goes ahead of every equal or later time
          at = 0;
          while (at < held && tbl[at].minute < c.minute_of_day) at++;
          for (int i = 0; i < at; i++) grown[i] = tbl[i];
          grown[at] = fresh;
          for (int i = at; i < held; i++) grown[i+1] = tbl[i];
          n = held + 1;
          lim = (cap > TBL_DEPTH) ? TBL_DEPTH : cap;
          // over the limit: drop the head, only one entry
          if (n > lim) begin
            r.evicted_flag = 1'b1;
            r.evicted_id = grown[0].id;
            r.evicted_minute = grown[0].minute;
            for (int i = 0; i < n - 1; i++) grown[i] = grown[i+1];
            n--;
          end
          for (int i = 0; i < n; i++) tbl[i] = grown[i];
          held = n;
          r.result_code = RES_OK;
          r = with_entry(r, fresh);
        end
      end else if (pos < 0) begin
        r.result_code = RES_NOT_FOUND;
      end else begin
        case (btst_action_t'(c.action))
          ACT_DELETE: begin
            fresh = tbl[pos];
            for (int i = pos; i < held - 1; i++) tbl[i] = tbl[i+1];
            held--;
            r.result_code = RES_OK;
            r = with_entry(r, fresh);
          end
          ACT_SET: begin
            if (c.status_code == STATUS_INVALID) begin
              r.result_code = RES_BAD_STATUS;
            end else begin
              tbl[pos].status = c.status_code;
              r.result_code = RES_OK;
            end
            r = with_entry(r, tbl[pos]);
          end
          default: begin
            r.result_code = RES_OK;
            r = with_entry(r, tbl[pos]);
          end
        endcase
      end
      r.entry_count = COUNT_W'(held);
      return r;
    endfunction

    function void note_command(btst_in_t c);
      owed_words.push_back(apply_command(c));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
        $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      end
    endtask

    task compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(btst_out_t got);
      btst_out_t want;
      if (owed_words.size() == 0) begin
        report_mismatch("result word with none owed, out_id", 32'(got.out_id), 32'd0);
      end else begin
        want = owed_words.pop_front();
        compare_field("result_code", 32'(got.result_code), 32'(want.result_code));
        compare_field("out_id", 32'(got.out_id), 32'(want.out_id));
        compare_field("out_gate", 32'(got.out_gate), 32'(want.out_gate));
        compare_field("out_minute", 32'(got.out_minute), 32'(want.out_minute));
        compare_field("out_status", 32'(got.out_status), 32'(want.out_status));
        compare_field("evicted_flag", 32'(got.evicted_flag), 32'(want.evicted_flag));
        compare_field("evicted_id", 32'(got.evicted_id), 32'(want.evicted_id));
        compare_field("evicted_minute", 32'(got.evicted_minute),
                      32'(want.evicted_minute));
        compare_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  btst_in_t in_word;
  logic out_strobe;
  btst_out_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  sorted_table_tracker tracker;
  int send_idle_pct;
  logic [ID_W-1:0] id_pool[POOL_SIZE];

  bounded_time_sorted_table #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10000000;
    $display("tb_bounded_time_sorted_table NOT OK");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_result(out_word);
  end

  function btst_in_t make_word(btst_action_t act, logic [ID_W-1:0] id,
                               logic [GATE_W-1:0] gate, logic [MINUTE_W-1:0] minute,
                               logic [STATUS_W-1:0] status);
    btst_in_t w;
    w.action = act;
    w.entry_id = id;
    w.gate_number = gate;
    w.minute_of_day = minute;
    w.status_code = status;
    return w;
  endfunction

  // random command word: ids often reused so finds and duplicates are common
  function btst_in_t random_word();
    btst_in_t w;
    int r;
    r = $urandom_range(99);
    if (r < 45) w.action = ACT_INSERT;
    else if (r < 60) w.action = ACT_DELETE;
    else if (r < 80) w.action = ACT_SET;
    else w.action = ACT_LOOKUP;
    r = $urandom_range(99);
    if (r < 40) w.entry_id = id_pool[$urandom_range(POOL_SIZE - 1, 0)];
    else if (r < 70) w.entry_id = tracker.pick_held_id();
    else w.entry_id = ID_W'($urandom);
    w.gate_number = GATE_W'($urandom);
    // ties and out-of-range minutes get extra weight
    r = $urandom_range(99);
    if (r < 20) begin
      case ($urandom_range(5))
        0: w.minute_of_day = 11'd0;
        1: w.minute_of_day = 11'd1;
        2: w.minute_of_day = 11'd720;
        3: w.minute_of_day = 11'd1439;
        4: w.minute_of_day = 11'd1440;
        default: w.minute_of_day = 11'd2047;
      endcase
    end else if (r < 26) begin
      w.minute_of_day = MINUTE_W'($urandom_range(2047, 1440));
    end else begin
      w.minute_of_day = MINUTE_W'($urandom_range(1439, 0));
    end
    w.status_code = STATUS_W'($urandom_range(7));
    return w;
  endfunction

  // offer one command word, with random idle cycles ahead of it
  task send_command(btst_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    tracker.note_command(w);
  endtask

  // limit write, only once the table is idle
  task write_limit(logic [CAP_W-1:0] v);
    start <= 1'b0;
    while (tracker.pending() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_limit(v);
  endtask

  initial begin
    logic [CAP_W-1:0] limits[7];
    int sent;
    tracker = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    send_idle_pct = 17;
    sent = 0;
    limits = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd17, 5'd10};
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, field extremes, ties, bad status, eviction
    send_command(make_word(ACT_LOOKUP, 16'h1234, 8'h00, 11'd0, 3'd0));
    send_command(make_word(ACT_DELETE, 16'h1234, 8'h00, 11'd0, 3'd0));
    send_command(make_word(ACT_SET, 16'h1234, 8'h00, 11'd0, 3'd3));
    send_command(make_word(ACT_INSERT, 16'h0000, 8'h00, 11'd0, STATUS_INVALID));
    send_command(make_word(ACT_INSERT, 16'hffff, 8'hff, 11'd2047, 3'd6));
    send_command(make_word(ACT_INSERT, 16'h0000, 8'h05, 11'd100, 3'd1));
    send_command(make_word(ACT_INSERT, 16'h0100, 8'h10, 11'd1439, 3'd1));
    send_command(make_word(ACT_INSERT, 16'h0200, 8'h20, 11'd1439, 3'd2));
    send_command(make_word(ACT_SET, 16'h0100, 8'h00, 11'd0, STATUS_INVALID));
    send_command(make_word(ACT_SET, 16'h0200, 8'h00, 11'd0, 3'd5));
    send_command(make_word(ACT_SET, 16'h9999, 8'h00, 11'd0, STATUS_INVALID));
    send_command(make_word(ACT_LOOKUP, 16'hffff, 8'h00, 11'd0, 3'd0));
    send_command(make_word(ACT_DELETE, 16'h0200, 8'h00, 11'd0, 3'd0));
    send_command(make_word(ACT_LOOKUP, 16'h0200, 8'h00, 11'd0, 3'd0));
    // fill past the reset limit of ten
    for (int k = 0; k < 8; k++) begin
      send_command(make_word(ACT_INSERT, ID_W'(16'h1000 + k), GATE_W'(k),
                             MINUTE_W'(500 + 37 * k), STATUS_W'(k % 7)));
    end
    // new entry is earlier than the head time on a full table and evicts itself
    send_command(make_word(ACT_INSERT, 16'h2000, 8'h77, 11'd0, 3'd4));

    // random phases, one per limit setting
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int k = 0; k < RAND_WORDS / 7 + 1; k++) begin
        if (sent < RAND_WORDS / 3) send_idle_pct = 17;
        else if (sent < 2 * RAND_WORDS / 3) send_idle_pct = 75;
        else send_idle_pct = 0;
        send_command(random_word());
        sent++;
      end
    end
    write_limit(5'(CAP_RESET));
    send_command(make_word(ACT_LOOKUP, id_pool[0], 8'h00, 11'd0, 3'd0));

    // drain
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("tb_bounded_time_sorted_table OK");
    end else begin
      $display("tb_bounded_time_sorted_table NOT OK");
    end
    $finish;
  end

endmodule

// File: bounded_time_sorted_table.f
rtl/btst_pkg.sv
rtl/btst_mem.sv
rtl/btst_cmp.sv
rtl/btst_ctrl.sv
rtl/bounded_time_sorted_table.sv
tb/tb_bounded_time_sorted_table.sv
